/* rtl/eps_pkg.sv */
// ----------------------------------------------------------------------------
// eps_pkg: shared types and constants of the pendulum stepper
// Register indexes, CORDIC constants and controller command types.
// ----------------------------------------------------------------------------
`default_nettype none
package eps_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_START_VELOCITY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_ANGLE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NATURAL_FREQ   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TIME_STEP      = 2'd3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned OutIdxW = 16;
  localparam int unsigned OutStW = 24;

  localparam logic signed [63:0] Q16TwoPi  = 64'sd411775;
  localparam logic signed [63:0] Q16Pi     = 64'sd205887;
  localparam logic signed [63:0] Q16HalfPi = 64'sd102944;
  localparam logic signed [35:0] CordicGainInv = 36'sh026DD3B6A;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FOLD, ST_CORDIC, ST_MUL1, ST_MUL2, ST_UPDATE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic fold;
    logic seed;
    logic cordic;
    logic mul1;
    logic mul2;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } status_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] v;
    begin
      case (i)
        5'd0: v = 36'sh03243F6A8;  5'd1: v = 36'sh01DAC6705;
        5'd2: v = 36'sh00FADBAFC;  5'd3: v = 36'sh007F56EA6;
        5'd4: v = 36'sh003FEAB76;  5'd5: v = 36'sh001FFD55B;
        5'd6: v = 36'sh000FFFAAA;  5'd7: v = 36'sh0007FFF55;
        5'd8: v = 36'sh0003FFFEA;  5'd9: v = 36'sh0001FFFFD;
        5'd10: v = 36'sh0000FFFFF; 5'd11: v = 36'sh00007FFFF;
        5'd12: v = 36'sh00003FFFF; 5'd13: v = 36'sh00001FFFF;
        5'd14: v = 36'sh00000FFFF; 5'd15: v = 36'sh000007FFF;
        5'd16: v = 36'sh3FFF; 5'd17: v = 36'sh1FFF; 5'd18: v = 36'sh0FFF;
        5'd19: v = 36'sh07FF; 5'd20: v = 36'sh03FF; 5'd21: v = 36'sh01FF;
        5'd22: v = 36'sh00FF; 5'd23: v = 36'sh007F; 5'd24: v = 36'sh003F;
        5'd25: v = 36'sh001F; 5'd26: v = 36'sh000F; 5'd27: v = 36'sh0007;
        5'd28: v = 36'sh0003; 5'd29: v = 36'sh0001;
        default: v = 36'sh0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/eps_if.sv */
// ----------------------------------------------------------------------------
// eps_in_if / eps_out_if: valid/ready channels of the pendulum stepper
// Input carries the restart flag; output carries one result beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface eps_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface eps_out_if;
  logic valid;
  logic ready;
  logic [15:0] step_index;
  logic signed [23:0] angle_out;
  logic signed [23:0] velocity_out;
  logic saturated;
  modport source (output valid, output step_index, output angle_out,
                  output velocity_out, output saturated, input ready);
  modport sink (input valid, input step_index, input angle_out,
                input velocity_out, input saturated, output ready);
endinterface
`default_nettype wire

/* rtl/eps_ctrl.sv */
// ----------------------------------------------------------------------------
// eps_ctrl: controller of the pendulum stepper
// Sequences a reload, or fold, CORDIC, multiply and update steps, for one beat.
// ----------------------------------------------------------------------------
`default_nettype none
module eps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_restart,
  output logic                   in_ready,
  output logic                   res_load,
  input  wire logic              res_free,
  input  eps_pkg::status_t       status,
  output eps_pkg::cmd_t          cmd
);
  eps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eps_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = in_restart ? eps_pkg::ST_OUT : eps_pkg::ST_FOLD;
      end
      eps_pkg::ST_FOLD: state_nxt = eps_pkg::ST_CORDIC;
      eps_pkg::ST_CORDIC: begin
        if (status.cordic_done) state_nxt = eps_pkg::ST_MUL1;
      end
      eps_pkg::ST_MUL1: state_nxt = eps_pkg::ST_MUL2;
      eps_pkg::ST_MUL2: state_nxt = eps_pkg::ST_UPDATE;
      eps_pkg::ST_UPDATE: state_nxt = eps_pkg::ST_OUT;
      eps_pkg::ST_OUT: begin
        if (res_free) state_nxt = eps_pkg::ST_IDLE;
      end
      default: state_nxt = eps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state_r)
      eps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid & in_restart;
        cmd.fold = in_valid & ~in_restart;
      end
      eps_pkg::ST_FOLD: cmd.seed = 1'b1;
      eps_pkg::ST_CORDIC: cmd.cordic = 1'b1;
      eps_pkg::ST_MUL1: cmd.mul1 = 1'b1;
      eps_pkg::ST_MUL2: cmd.mul2 = 1'b1;
      eps_pkg::ST_UPDATE: cmd.update = 1'b1;
      eps_pkg::ST_OUT: res_load = res_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/eps_datapath.sv */
// ----------------------------------------------------------------------------
// eps_datapath: arithmetic of the pendulum stepper
// Angle folding, shared CORDIC rotator, multiplies and saturating update.
// ----------------------------------------------------------------------------
`default_nettype none
module eps_datapath #(
  parameter int unsigned STATE_WIDTH = 24,
  parameter int unsigned CORDIC_ITERATIONS = 16,
  parameter int unsigned STEP_COUNT_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  eps_pkg::cmd_t                    cmd,
  output eps_pkg::status_t                 status,
  input  wire logic [23:0]                 start_velocity,
  input  wire logic [23:0]                 start_angle,
  input  wire logic [15:0]                 natural_freq,
  input  wire logic [15:0]                 time_step,
  output logic [STEP_COUNT_WIDTH-1:0]      step_cnt,
  output logic signed [STATE_WIDTH-1:0]    angle,
  output logic signed [STATE_WIDTH-1:0]    velocity,
  output logic                             clipped
);
  localparam int unsigned ItW = $clog2(CORDIC_ITERATIONS + 1);
  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned WW = ((SW > 40) ? SW : 40) + 2;
  localparam logic signed [WW-1:0] StHi = WW'((64'sd1 <<< (SW-1)) - 1);
  localparam logic signed [WW-1:0] StLo = WW'(-(64'sd1 <<< (SW-1)));
  localparam logic signed [SW:0] RecipK =
    (SW+1)'(((64'sd1 <<< SW) + eps_pkg::Q16TwoPi - 64'sd1) / eps_pkg::Q16TwoPi);

  logic signed [SW-1:0] angle_r, velocity_r;
  logic [STEP_COUNT_WIDTH-1:0] cnt_r;
  logic clip_r;
  logic signed [35:0] x_r, y_r, z_r;
  logic [ItW-1:0] it_r;
  logic signed [32:0] w2_r;
  logic signed [SW+1:0] da_r;
  logic signed [63:0] acc_r;
  logic signed [39:0] dv_r;
  logic signed [SW-1:0] q_r;
  logic signed [2*SW:0] q_prod;

  assign q_prod = angle_r * RecipK;

  // Angle folding into [-pi/2, pi/2]; the quotient is a reciprocal estimate
  // that is off by at most one and is corrected below.
  logic signed [63:0] rem, r;
  always_comb begin
    rem = 64'(angle_r) - 64'(q_r) * eps_pkg::Q16TwoPi;
    r = rem;
    if (r < 0) r = r + eps_pkg::Q16TwoPi;
    else if (r >= eps_pkg::Q16TwoPi) r = r - eps_pkg::Q16TwoPi;
    if (r > eps_pkg::Q16Pi) r = r - eps_pkg::Q16TwoPi;
    if (r > eps_pkg::Q16HalfPi) r = eps_pkg::Q16Pi - r;
    else if (r < -eps_pkg::Q16HalfPi) r = -eps_pkg::Q16Pi - r;
  end

  logic signed [35:0] xs, ys, atn;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign atn = eps_pkg::atan_q30(5'(it_r));
  assign status.cordic_done = (it_r == ItW'(CORDIC_ITERATIONS));

  logic signed [21:0] sin_q16;
  assign sin_q16 = 22'(y_r >>> 14);

  logic signed [WW-1:0] v_sum, a_sum;
  logic signed [WW-1:0] sv_ext, sa_ext;
  assign v_sum = WW'(velocity_r) + WW'(dv_r);
  assign a_sum = WW'(angle_r) + WW'(da_r);
  assign sv_ext = WW'($signed(start_velocity));
  assign sa_ext = WW'($signed(start_angle));

  function automatic logic signed [SW-1:0] sat(input logic signed [WW-1:0] v);
    begin
      if (v > StHi) return SW'(StHi);
      if (v < StLo) return SW'(StLo);
      return SW'(v);
    end
  endfunction

  function automatic logic ovf(input logic signed [WW-1:0] v);
    begin
      return (v > StHi) || (v < StLo);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      velocity_r <= '0;
      cnt_r <= '0;
      clip_r <= 1'b0;
      it_r <= '0;
    end else begin
      if (cmd.load) begin
        velocity_r <= sat(sv_ext);
        angle_r <= sat(sa_ext);
        clip_r <= ovf(sv_ext) | ovf(sa_ext);
        cnt_r <= '0;
      end
      if (cmd.fold) begin
        q_r <= SW'(q_prod >>> SW);
        w2_r <= $signed({1'b0, 32'(natural_freq) * 32'(natural_freq)});
        da_r <= (SW+2)'((64'(velocity_r) * $signed({1'b0, time_step})) >>> 16);
      end
      if (cmd.seed) begin
        x_r <= eps_pkg::CordicGainInv;
        y_r <= '0;
        z_r <= 36'(r <<< 14);
        it_r <= '0;
      end
      if (cmd.cordic && !status.cordic_done) begin
        if (z_r >= 0) begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atn;
        end else begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atn;
        end
        it_r <= it_r + 1'b1;
      end
      if (cmd.mul1) acc_r <= -(64'(w2_r) * 64'(sin_q16));
      if (cmd.mul2) dv_r <= 40'(((acc_r >>> 16) * $signed({1'b0, time_step})) >>> 16);
      if (cmd.update) begin
        velocity_r <= sat(v_sum);
        angle_r <= sat(a_sum);
        clip_r <= ovf(v_sum) | ovf(a_sum);
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign step_cnt = cnt_r;
  assign angle = angle_r;
  assign velocity = velocity_r;
  assign clipped = clip_r;
endmodule
`default_nettype wire

/* rtl/euler_pendulum_step.sv */
// ----------------------------------------------------------------------------
// euler_pendulum_step: fixed-point forward Euler pendulum stepper
// One result beat per input beat; restart reloads, otherwise one step.
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// in_     | in  | restart
// out_    | out | step_index, angle_out, velocity_out, saturated
// cfg_    | in  | we, idx, data (write only)
// A step passes the fold, the CORDIC rotator loop, two multiplies and the
// update before its result is loaded; a restart loads its result directly.
// The next input beat is taken in idle, after the result is loaded. One beat
// is in flight at a time; a result waiting in the output register stalls the
// controller.
// Reset is synchronous and restores the register defaults and a zero state.
`default_nettype none
module euler_pendulum_step #(
  parameter int unsigned STATE_WIDTH = 24,
  parameter int unsigned CORDIC_ITERATIONS = 16,
  parameter int unsigned STEP_COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  eps_in_if.sink                             in_ch,
  eps_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [eps_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [eps_pkg::CfgDataW-1:0]  cfg_data
);
  logic [23:0] start_velocity_r, start_angle_r;
  logic [15:0] natural_freq_r, time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_velocity_r <= 24'd0;
      start_angle_r <= 24'd65536;
      natural_freq_r <= 16'd256;
      time_step_r <= 16'd6554;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        eps_pkg::REG_START_VELOCITY: start_velocity_r <= cfg_data;
        eps_pkg::REG_START_ANGLE:    start_angle_r <= cfg_data;
        eps_pkg::REG_NATURAL_FREQ:   natural_freq_r <= cfg_data[15:0];
        eps_pkg::REG_TIME_STEP:      time_step_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  eps_pkg::cmd_t cmd;
  eps_pkg::status_t status;
  logic res_load, res_free;
  logic out_valid_r;
  logic [STEP_COUNT_WIDTH-1:0] step_cnt;
  logic signed [STATE_WIDTH-1:0] angle, velocity;
  logic clipped;

  assign res_free = !out_valid_r || out_ch.ready;

  eps_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_restart(in_ch.restart), .in_ready(in_ch.ready),
    .res_load, .res_free, .status, .cmd
  );

  eps_datapath #(
    .STATE_WIDTH(STATE_WIDTH), .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .STEP_COUNT_WIDTH(STEP_COUNT_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .status,
    .start_velocity(start_velocity_r), .start_angle(start_angle_r),
    .natural_freq(natural_freq_r), .time_step(time_step_r),
    .step_cnt, .angle, .velocity, .clipped
  );

  logic [15:0] idx_r;
  logic [23:0] ang_r, vel_r;
  logic sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      idx_r <= 16'(32'(step_cnt));
      ang_r <= 24'(64'(angle));
      vel_r <= 24'(64'(velocity));
      sat_r <= clipped;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.step_index = idx_r;
  assign out_ch.angle_out = ang_r;
  assign out_ch.velocity_out = vel_r;
  assign out_ch.saturated = sat_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a beat is in flight");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote an untaken beat");
  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid_r)
    else $error("loaded result not presented");
endmodule
`default_nettype wire

/* sim/euler_pendulum_step_tb.sv */
// ----------------------------------------------------------------------------
// euler_pendulum_step_tb: self-checking bench of the pendulum stepper
// Drives restart and step beats in random bursts, predicts every result beat
// with an independent fixed-point Euler and CORDIC model, and compares each
// output beat field by field under random receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_pendulum_step_tb;

  typedef struct packed {
    logic [15:0] step_index;
    logic [23:0] angle;
    logic [23:0] velocity;
    logic        saturated;
  } pend_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [eps_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [eps_pkg::CfgDataW-1:0] cfg_data = '0;

  eps_in_if in_ch ();
  eps_out_if out_ch ();

  euler_pendulum_step uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state and register copies.
  logic [23:0] p_start_vel, p_start_ang;
  logic [15:0] p_freq, p_dt;
  longint p_angle, p_vel;
  logic [15:0] p_count;

  bit restart_q[$];
  pend_result_t expected_q[$];
  int errors = 0;
  int mismatches = 0;
  int n_results = 0;
  int n_restarts = 0;
  int n_sat = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  bit hold_send = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip24(longint v, inout bit c);
    if (v > 64'sd8388607) begin c = 1; return 64'sd8388607; end
    if (v < -64'sd8388608) begin c = 1; return -64'sd8388608; end
    return v;
  endfunction

  function automatic longint pend_sine(longint a);
    longint r, x, y, z, xs, ys;
    longint atan_tab[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF};
    r = a % 411775;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    if (r > 102944) r = 205887 - r;
    else if (r < -102944) r = -205887 - r;
    x = 64'h26DD3B6A; y = 0; z = r * 16384;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin x -= ys; y += xs; z -= atan_tab[i]; end
      else begin x += ys; y -= xs; z += atan_tab[i]; end
    end
    return y >>> 14;
  endfunction

  function automatic pend_result_t pendulum_advance(bit restart);
    pend_result_t res;
    bit c;
    longint w2, s, accel, dv, da, old_a;
    c = 0;
    if (restart) begin
      p_vel = clip24(longint'(signed'(p_start_vel)), c);
      p_angle = clip24(longint'(signed'(p_start_ang)), c);
      p_count = 0;
    end else begin
      w2 = longint'(p_freq) * longint'(p_freq);
      s = pend_sine(p_angle);
      accel = floor_shr(-(w2 * s), 16);
      dv = floor_shr(accel * longint'(p_dt), 16);
      da = floor_shr(p_vel * longint'(p_dt), 16);
      old_a = p_angle;
      p_vel = clip24(p_vel + dv, c);
      p_angle = clip24(old_a + da, c);
      p_count = p_count + 16'd1;
    end
    res.step_index = p_count;
    res.angle = p_angle[23:0];
    res.velocity = p_vel[23:0];
    res.saturated = c;
    return res;
  endfunction

  // Driver: bursts of beats with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_q.push_back(pendulum_advance(in_ch.restart));
      void'(restart_q.pop_front());
    end
    if (in_ch.valid && !in_ch.ready) begin
    end else if (hold_send || restart_q.size() == 0 || !rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid <= 1'b1;
      in_ch.restart <= restart_q[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(12, 1);
        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Monitor with its own stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    pend_result_t got, exp_r;
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.step_index, out_ch.angle_out, out_ch.velocity_out,
              out_ch.saturated};
      n_results <= n_results + 1;
      if (expected_q.size() == 0) begin
        errors <= errors + 1;
        if (mismatches < 10) $display("unexpected result beat %p", got);
        mismatches <= mismatches + 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.saturated) n_sat <= n_sat + 1;
        if (got !== exp_r) begin
          errors <= errors + 1;
          if (mismatches < 10)
            $display({"mismatch: expected idx %0d ang %h vel %h sat %b, ",
                      "got idx %0d ang %h vel %h sat %b"},
                     exp_r.step_index, exp_r.angle, exp_r.velocity, exp_r.saturated,
                     got.step_index, got.angle, got.velocity, got.saturated);
          mismatches <= mismatches + 1;
        end
      end
    end
    stall_phase <= (stall_phase + 1) % 37;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_phase < 12) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(2) != 0);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic reg_write(logic [eps_pkg::CfgIdxW-1:0] idx,
                           logic [eps_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    case (idx)
      eps_pkg::REG_START_VELOCITY: p_start_vel = val;
      eps_pkg::REG_START_ANGLE: p_start_ang = val;
      eps_pkg::REG_NATURAL_FREQ: p_freq = val[15:0];
      default: p_dt = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_all();
    while (restart_q.size() != 0 || expected_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_run(int n, int restart_pct);
    for (int i = 0; i < n; i++) restart_q.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    p_start_vel = 24'd0; p_start_ang = 24'd65536; p_freq = 16'd256; p_dt = 16'd6554;
    p_angle = 0; p_vel = 0; p_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: steps from the zero reset state, then default restart.
    restart_q.push_back(0); restart_q.push_back(0);
    restart_q.push_back(1); push_run(3, 0);
    drain_all();
    reg_write(eps_pkg::REG_START_VELOCITY, 24'h7FFFFF);
    reg_write(eps_pkg::REG_START_ANGLE, 24'h800000);
    reg_write(eps_pkg::REG_NATURAL_FREQ, 24'h00FFFF);
    reg_write(eps_pkg::REG_TIME_STEP, 24'h00FFFF);
    restart_q.push_back(1); push_run(4, 0);
    drain_all();
    reg_write(eps_pkg::REG_START_VELOCITY, 24'h800000);
    reg_write(eps_pkg::REG_START_ANGLE, 24'h7FFFFF);
    reg_write(eps_pkg::REG_NATURAL_FREQ, 24'd0);
    reg_write(eps_pkg::REG_TIME_STEP, 24'd0);
    restart_q.push_back(1); push_run(3, 0);
    drain_all();
    // Random phases, with every register value random.
    for (int ph = 0; ph < 12; ph++) begin
      reg_write(eps_pkg::REG_START_VELOCITY, 24'($urandom()));
      reg_write(eps_pkg::REG_START_ANGLE, 24'($urandom()));
      reg_write(eps_pkg::REG_NATURAL_FREQ,
                (ph % 3 == 0) ? 24'($urandom()) : 24'($urandom_range(1024)));
      reg_write(eps_pkg::REG_TIME_STEP, 24'($urandom()));
      restart_q.push_back(1);
      push_run(55, 8);
      if (ph == 5) begin
        while (restart_q.size() >= 30) @(posedge clk);
        hold_send = 1'b1;
        while (expected_q.size() != 0 || in_ch.valid) @(posedge clk);
        hold_send = 1'b0;
      end
      drain_all();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycles > 64'd8000000);
    if (!stim_done) begin
      $display("Some tests failed");
      $finish;
    end else begin
      $display("Covered %0d result beats, %0d saturated, including restarts, ",
               n_results, n_sat);
      $display("register extremes, and random register phases with a pause.");
      if (errors == 0 && expected_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
    end
  end
endmodule
`default_nettype wire
